// ===== hw/rtl/lssu_pkg.sv =====
package lssu_pkg;

  // Default RAM size in bytes
  localparam int unsigned RAM_BYTES_DEF = 256;

  // Register file geometry
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned WORD_W    = 32;

  // Stack pointer register
  localparam logic [REG_IDX_W-1:0] SP_INDEX = 4'd13;

  // Operation codes
  typedef enum logic [3:0] {
    OP_LDR      = 4'd0,
    OP_LDRB     = 4'd1,
    OP_LDRH     = 4'd2,
    OP_LDRSB    = 4'd3,
    OP_LDRSH    = 4'd4,
    OP_STR      = 4'd5,
    OP_STRB     = 4'd6,
    OP_STRH     = 4'd7,
    OP_PUSH     = 4'd8,
    OP_POP      = 4'd9,
    OP_REGWRITE = 4'd10,
    OP_REGREAD  = 4'd11
  } op_e;

  // Register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } rf_wr_t;

  // Register file read port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
  } rf_rd_t;

endpackage

// ===== hw/rtl/lssu_mod_unit.sv =====
// Reduces a 32-bit address modulo the RAM size, eight bits per cycle.
module lssu_mod_unit #(
  parameter int unsigned RAM_BYTES = lssu_pkg::RAM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  value_i,
  output logic                         done_o,
  output logic [$clog2(RAM_BYTES)-1:0] rem_o
);
  import lssu_pkg::*;

  localparam int unsigned AW       = $clog2(RAM_BYTES);
  localparam int unsigned BitsStep = 8;
  localparam int unsigned Steps    = WORD_W / BitsStep;
  localparam int unsigned CntW     = $clog2(Steps);
  localparam logic [AW:0] Modulus  = (AW + 1)'(RAM_BYTES);
  localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

  logic [31:0]     val_q, val_d;
  logic [AW-1:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            act_q, act_d;
  logic            done_q, done_d;
  logic [AW-1:0]   rem_step;

  // Restoring reduction over the top eight bits of the shift register
  always_comb begin
    logic [AW:0] ext;
    rem_step = rem_q;
    for (int k = 0; k < BitsStep; k++) begin
      ext = {rem_step, val_q[31 - k]};
      if (ext >= Modulus) begin
        ext = ext - Modulus;
      end
      rem_step = ext[AW-1:0];
    end
  end

  // Sequencing
  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    act_d  = act_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d = value_i;
      rem_d = '0;
      cnt_d = '0;
      act_d = 1'b1;
    end else if (act_q) begin
      val_d = val_q << BitsStep;
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        act_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/lssu_byte_ram.sv =====
// Byte-wide RAM, one write and one registered read per cycle.
// Swept to zero after reset, one byte per cycle; writes on we_i are ignored meanwhile.
module lssu_byte_ram #(
  parameter int unsigned RAM_BYTES = lssu_pkg::RAM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [$clog2(RAM_BYTES)-1:0] waddr_i,
  input  logic [7:0]                   wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(RAM_BYTES)-1:0] raddr_i,
  output logic [7:0]                   rdata_o,
  output logic                         clearing_o
);
  import lssu_pkg::*;

  localparam int unsigned AW = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] AddrLast = AW'(RAM_BYTES - 1);

  logic [7:0]    mem_q [RAM_BYTES];
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_act_q, clr_act_d;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Clearing sweep
  always_comb begin
    clr_d     = clr_q;
    clr_act_d = clr_act_q;
    if (clr_act_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == AddrLast) begin
        clr_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      clr_act_q <= 1'b1;
    end else begin
      clr_q     <= clr_d;
      clr_act_q <= clr_act_d;
    end
  end

  // Write port mux: sweep has the port while active
  assign mem_we    = clr_act_q | we_i;
  assign mem_waddr = clr_act_q ? clr_q : waddr_i;
  assign mem_wdata = clr_act_q ? 8'h00 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_act_q;

endmodule

// ===== hw/rtl/lssu_reg_file.sv =====
// 16 x 32 register file, one write and one registered read per cycle.
// Entries never written read as zero.
module lssu_reg_file (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lssu_pkg::rf_wr_t       wr_i,
  input  lssu_pkg::rf_rd_t       rd_i,
  output logic [31:0]            rdata_o
);
  import lssu_pkg::*;

  logic [WORD_W-1:0]    mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [WORD_W-1:0]    rdata_q;

  // Valid bits stand in for the zero reset of the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= vld_q[rd_i.addr] ? mem_q[rd_i.addr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/load_store_stack_unit.sv =====
// Channel   | Ports                                             | Direction
// ----------+---------------------------------------------------+----------
// request   | start_i, busy_o, operation_i, base_i, offset_i,   | in
//           | store_data_i, register_list_i, register_index_i   |
// result    | done_o, read_data_o                               | out
//
// A request is taken when start_i is high and busy_o low; one result follows,
// shown for one cycle with done_o. RAM moves one byte per cycle, n bytes for a
// load or store and four per listed register for push and pop; a non power of
// two RAM size adds a modulo reduction of the start address to RAM operations.
// After reset busy_o stays high while the RAM is zeroed. The receiver cannot
// stall; busy_o is low in the cycle the result is shown.
module load_store_stack_unit #(
  parameter int unsigned RAM_BYTES = lssu_pkg::RAM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] base_i,
  input  logic [31:0] offset_i,
  input  logic [31:0] store_data_i,
  input  logic [15:0] register_list_i,
  input  logic [3:0]  register_index_i,
  output logic        done_o,
  output logic [31:0] read_data_o
);
  import lssu_pkg::*;

  localparam int unsigned AW      = $clog2(RAM_BYTES);
  localparam bit          RamPow2 = (RAM_BYTES & (RAM_BYTES - 1)) == 0;
  localparam logic [AW-1:0] AddrLast = AW'(RAM_BYTES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RFRD,
    ST_SPRD,
    ST_ADDR,
    ST_MODW,
    ST_LOAD,
    ST_STORE,
    ST_PUSHRD,
    ST_PUSHWR,
    ST_SPWR
  } state_e;

  state_e        state_q, state_d;
  op_e           op_q, op_d, op_in;
  logic [31:0]   addr_q, addr_d;
  logic [AW-1:0] r_q, r_d;
  logic [31:0]   data_q, data_d;
  logic [15:0]   list_q, list_d;
  logic [31:0]   sp_q, sp_d;
  logic [6:0]    tot_q, tot_d;
  logic          pend_q, pend_d;
  logic [1:0]    bsel_q, bsel_d;
  logic [1:0]    rbyte_q, rbyte_d;
  logic          done_q, done_d;
  logic [31:0]   result_q, result_d;

  logic          accept;
  logic [31:0]   addr_nx;
  logic [AW-1:0] r_nx;
  logic [4:0]    cnt;
  logic [31:0]   four_cnt;
  logic [3:0]    low_idx;
  logic [31:0]   word_in;
  logic [31:0]   load_ext;

  rf_wr_t        rf_wr;
  rf_rd_t        rf_rd;
  logic [31:0]   rf_rdata;

  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic          ram_clearing;

  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;

  function automatic logic [4:0] pop_count(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [3:0] lowest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  // Units
  lssu_byte_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_ram (
    .clk_i,
    .rst_ni,
    .we_i      (ram_we),
    .waddr_i   (r_q),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_i   (r_q),
    .rdata_o   (ram_rdata),
    .clearing_o(ram_clearing)
  );

  lssu_reg_file u_rf (
    .clk_i,
    .rst_ni,
    .wr_i   (rf_wr),
    .rd_i   (rf_rd),
    .rdata_o(rf_rdata)
  );

  lssu_mod_unit #(
    .RAM_BYTES(RAM_BYTES)
  ) u_mod (
    .clk_i,
    .rst_ni,
    .start_i(mod_start),
    .value_i(addr_q),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // Helpers
  assign accept   = start_i && (state_q == ST_IDLE);
  assign op_in    = op_e'(operation_i);
  assign addr_nx  = addr_q + 32'd1;
  assign r_nx     = ((addr_nx == '0) || (r_q == AddrLast)) ? '0 : r_q + 1'b1;
  assign cnt      = pop_count(list_q);
  assign four_cnt = {25'd0, cnt, 2'b00};
  assign low_idx  = lowest_set(list_q);
  assign word_in  = {data_q[23:0], ram_rdata};

  always_comb begin
    unique case (op_q)
      OP_LDRSB: load_ext = {{24{data_q[7]}}, data_q[7:0]};
      OP_LDRSH: load_ext = {{16{data_q[15]}}, data_q[15:0]};
      default:  load_ext = data_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    addr_d    = addr_q;
    r_d       = r_q;
    data_d    = data_q;
    list_d    = list_q;
    sp_d      = sp_q;
    tot_d     = tot_q;
    pend_d    = 1'b0;
    bsel_d    = bsel_q;
    rbyte_d   = rbyte_q;
    done_d    = 1'b0;
    result_d  = result_q;
    rf_wr     = '0;
    rf_rd     = '0;
    ram_we    = 1'b0;
    ram_wdata = data_q[31:24];
    ram_re    = 1'b0;
    mod_start = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        if (!ram_clearing) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_d    = op_in;
          addr_d  = base_i + offset_i;
          list_d  = register_list_i;
          rbyte_d = '0;
          data_d  = '0;
          unique case (op_in)
            OP_LDR: begin
              tot_d   = 7'd4;
              state_d = ST_ADDR;
            end
            OP_LDRB, OP_LDRSB: begin
              tot_d   = 7'd1;
              state_d = ST_ADDR;
            end
            OP_LDRH, OP_LDRSH: begin
              tot_d   = 7'd2;
              state_d = ST_ADDR;
            end
            OP_STR: begin
              tot_d   = 7'd4;
              data_d  = store_data_i;
              state_d = ST_ADDR;
            end
            OP_STRB: begin
              tot_d   = 7'd1;
              data_d  = {store_data_i[7:0], 24'd0};
              state_d = ST_ADDR;
            end
            OP_STRH: begin
              tot_d   = 7'd2;
              data_d  = {store_data_i[15:0], 16'd0};
              state_d = ST_ADDR;
            end
            OP_PUSH, OP_POP: begin
              rf_rd.en   = 1'b1;
              rf_rd.addr = SP_INDEX;
              state_d    = ST_SPRD;
            end
            OP_REGWRITE: begin
              rf_wr.en   = 1'b1;
              rf_wr.addr = register_index_i;
              rf_wr.data = store_data_i;
              result_d   = '0;
              done_d     = 1'b1;
            end
            OP_REGREAD: begin
              rf_rd.en   = 1'b1;
              rf_rd.addr = register_index_i;
              state_d    = ST_RFRD;
            end
            default: begin
              result_d = '0;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      ST_RFRD: begin
        result_d = rf_rdata;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end

      // Stack pointer is in; form start address and new SP
      ST_SPRD: begin
        tot_d = {cnt, 2'b00};
        if (op_q == OP_PUSH) begin
          sp_d   = rf_rdata - four_cnt;
          addr_d = rf_rdata - four_cnt;
        end else begin
          sp_d   = rf_rdata + four_cnt;
          addr_d = rf_rdata;
        end
        state_d = ST_ADDR;
      end

      // Reduce the start address into the RAM
      ST_ADDR: begin
        if (RamPow2) begin
          r_d = addr_q[AW-1:0];
          priority if (op_q == OP_PUSH) begin
            state_d = ST_PUSHRD;
          end else if (op_q == OP_STR || op_q == OP_STRB || op_q == OP_STRH) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_LOAD;
          end
        end else begin
          mod_start = 1'b1;
          state_d   = ST_MODW;
        end
      end

      ST_MODW: begin
        if (mod_done) begin
          r_d = mod_rem;
          priority if (op_q == OP_PUSH) begin
            state_d = ST_PUSHRD;
          end else if (op_q == OP_STR || op_q == OP_STRB || op_q == OP_STRH) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end

      // Byte reads for loads and pop: issue a read, collect its byte the cycle after
      ST_LOAD: begin
        if (tot_q != '0) begin
          ram_re = 1'b1;
          addr_d = addr_nx;
          r_d    = r_nx;
          tot_d  = tot_q - 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          data_d  = word_in;
          rbyte_d = rbyte_q + 1'b1;
          if (op_q == OP_POP && rbyte_q == 2'd3) begin
            rf_wr.en           = 1'b1;
            rf_wr.addr         = low_idx;
            rf_wr.data         = word_in;
            list_d[low_idx]    = 1'b0;
          end
        end
        if (tot_q == '0 && !pend_q) begin
          if (op_q == OP_POP) begin
            state_d = ST_SPWR;
          end else begin
            result_d = load_ext;
            done_d   = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end

      // Byte writes, most significant first
      ST_STORE: begin
        ram_we = 1'b1;
        data_d = data_q << 8;
        addr_d = addr_nx;
        r_d    = r_nx;
        tot_d  = tot_q - 1'b1;
        if (tot_q == 7'd1) begin
          result_d = '0;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      // Fetch the first listed register
      ST_PUSHRD: begin
        if (list_q == '0) begin
          state_d = ST_SPWR;
        end else begin
          rf_rd.en        = 1'b1;
          rf_rd.addr      = low_idx;
          list_d[low_idx] = 1'b0;
          bsel_d          = '0;
          state_d         = ST_PUSHWR;
        end
      end

      // Write the fetched word; fetch the next one with its last byte
      ST_PUSHWR: begin
        ram_we    = 1'b1;
        ram_wdata = rf_rdata[{~bsel_q, 3'b000} +: 8];
        addr_d    = addr_nx;
        r_d       = r_nx;
        bsel_d    = bsel_q + 1'b1;
        if (bsel_q == 2'd3) begin
          if (list_q != '0) begin
            rf_rd.en        = 1'b1;
            rf_rd.addr      = low_idx;
            list_d[low_idx] = 1'b0;
          end else begin
            state_d = ST_SPWR;
          end
        end
      end

      ST_SPWR: begin
        rf_wr.en   = 1'b1;
        rf_wr.addr = SP_INDEX;
        rf_wr.data = sp_q;
        result_d   = sp_q;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      op_q     <= OP_LDR;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
      tot_q    <= '0;
      bsel_q   <= '0;
      rbyte_q  <= '0;
      list_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      result_q <= result_d;
      tot_q    <= tot_d;
      bsel_q   <= bsel_d;
      rbyte_q  <= rbyte_d;
      list_q   <= list_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    r_q    <= r_d;
    data_q <= data_d;
    sp_q   <= sp_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign read_data_o = result_q;

endmodule
